[src/tes_pkg.sv]
// Package for the triangle element stiffness unit: payload structs, widths,
// register codes, reset values and small helpers. No dependencies.
package tes_pkg;

	localparam int NODE_COUNT = 1024;

	localparam int NODE_W  = 10;
	localparam int IDX_W   = 11;
	localparam int COORD_W = 16;
	localparam int DIFF_W  = 17;
	localparam int MAG_W   = 16;
	localparam int DREG_W  = 32;
	localparam int NUM_W   = 64;
	localparam int DET_W   = 35;
	localparam int DIV_W   = 36;
	localparam int QUO_W   = 48;
	localparam int K_W     = 48;
	localparam int ADDR_W  = 4;

	localparam logic [1:0] REG_D_NORMAL = 2'd0;
	localparam logic [1:0] REG_D_CROSS  = 2'd1;
	localparam logic [1:0] REG_D_SHEAR  = 2'd2;

	localparam logic signed [DREG_W-1:0] D_NORMAL_RST = 32'sd65536;
	localparam logic signed [DREG_W-1:0] D_CROSS_RST  = 32'sd0;
	localparam logic signed [DREG_W-1:0] D_SHEAR_RST  = 32'sd32768;

	typedef struct packed {
		logic [NODE_W-1:0]         node_a;
		logic [NODE_W-1:0]         node_b;
		logic [NODE_W-1:0]         node_c;
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by_coord;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
	} elem_t;

	typedef struct packed {
		logic [IDX_W-1:0]      row_index;
		logic [IDX_W-1:0]      col_index;
		logic signed [K_W-1:0] stiffness;
		logic                  degenerate;
		logic                  last;
	} trip_t;

	// per-entry bookkeeping that rides along the pipeline
	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             degen;
		logic             last;
		logic [DIV_W-1:0] dvsr;
	} meta_t;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [QUO_W-1:0] quo;
		logic             sat;
		logic             neg;
		meta_t            meta;
	} dstg_t;

	function automatic logic [NODE_W-1:0] node_wrap(input logic [NODE_W-1:0] n);
		logic [31:0] w;
		w = 32'(n) % NODE_COUNT;
		return w[NODE_W-1:0];
	endfunction

	function automatic logic signed [DIFF_W-1:0] sel3(input logic [1:0] s,
			input logic signed [DIFF_W-1:0] a0, input logic signed [DIFF_W-1:0] a1,
			input logic signed [DIFF_W-1:0] a2);
		logic signed [DIFF_W-1:0] r;
		case (s)
			2'd1: r = a1;
			2'd2: r = a2;
			default: r = a0;
		endcase
		return r;
	endfunction

	function automatic logic [MAG_W-1:0] mag17(input logic signed [DIFF_W-1:0] a);
		logic signed [DIFF_W-1:0] n;
		n = a[DIFF_W-1] ? -a : a;
		return n[MAG_W-1:0];
	endfunction

	function automatic logic [DREG_W-1:0] mag32(input logic signed [DREG_W-1:0] a);
		logic [DREG_W-1:0] n;
		n = a[DREG_W-1] ? DREG_W'(-a) : DREG_W'(a);
		return n;
	endfunction

endpackage

[src/triangle_element_stiffness_unit.sv]
// Constant-strain triangle stiffness unit: one element in, 36 triplets out.
// Depends on tes_pkg (payload structs, widths, register codes).
//
//  channel  | signals                              | moves
//  ---------+--------------------------------------+------------------------------
//  elem     | elem_valid, elem_stall, elem_data    | one triangle per transaction
//  trip     | trip_valid, trip_stall, trip_data    | one (row, col, K) triplet
//  apb      | psel penable pwrite paddr pwdata ... | D matrix registers
//
// The issue sequencer sends one entry per cycle, unless a trip stall holds it,
// into a pipeline (products, sum, 48 one-bit divide stages, rounding, output).
// A new element is taken while the previous one's last entry issues. A stall on
// trip with trip_valid high freezes the pipeline; nothing is lost or repeated.
// Reset clears valid bits, the sequencer and loads the D registers' defaults.
module triangle_element_stiffness_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         elem_valid,
	output logic                         elem_stall,
	input  tes_pkg::elem_t               elem_data,
	output logic                         trip_valid,
	input  logic                         trip_stall,
	output tes_pkg::trip_t               trip_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tes_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int DW = tes_pkg::DIFF_W;
	localparam int NSTG = tes_pkg::QUO_W;

	// ---------------- configuration ----------------
	logic signed [31:0] d_normal_q, d_cross_q, d_shear_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_normal_q <= tes_pkg::D_NORMAL_RST;
			d_cross_q  <= tes_pkg::D_CROSS_RST;
			d_shear_q  <= tes_pkg::D_SHEAR_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				tes_pkg::REG_D_NORMAL: d_normal_q <= pwdata;
				tes_pkg::REG_D_CROSS:  d_cross_q  <= pwdata;
				tes_pkg::REG_D_SHEAR:  d_shear_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			tes_pkg::REG_D_NORMAL: prdata = d_normal_q;
			tes_pkg::REG_D_CROSS:  prdata = d_cross_q;
			tes_pkg::REG_D_SHEAR:  prdata = d_shear_q;
			default: prdata = 32'd0;
		endcase
	end

	// ---------------- element hold and issue sequencer ----------------
	logic adv;
	logic out_vld_q;
	assign adv = !(out_vld_q && trip_stall);

	logic elem_vld_q;
	logic [1:0] ci_q, cj_q, cpq_q;
	logic [tes_pkg::NODE_W-1:0] n0_q, n1_q, n2_q;
	logic signed [DW-1:0] b0_q, b1_q, b2_q, c0_q, c1_q, c2_q;
	logic issue, last_issue, accept;

	assign last_issue = (ci_q == 2'd2) && (cj_q == 2'd2) && (cpq_q == 2'd3);
	assign issue      = elem_vld_q && adv;
	assign elem_stall = elem_vld_q && !(adv && last_issue);
	assign accept     = elem_valid && !elem_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_vld_q <= 1'b0;
			ci_q <= 2'd0;
			cj_q <= 2'd0;
			cpq_q <= 2'd0;
		end else begin
			if (accept)
				elem_vld_q <= 1'b1;
			else if (issue && last_issue)
				elem_vld_q <= 1'b0;
			if (issue) begin
				cpq_q <= cpq_q + 2'd1;
				if (cpq_q == 2'd3) begin
					if (cj_q == 2'd2) begin
						cj_q <= 2'd0;
						ci_q <= (ci_q == 2'd2) ? 2'd0 : ci_q + 2'd1;
					end else begin
						cj_q <= cj_q + 2'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n0_q <= tes_pkg::node_wrap(elem_data.node_a);
			n1_q <= tes_pkg::node_wrap(elem_data.node_b);
			n2_q <= tes_pkg::node_wrap(elem_data.node_c);
			b0_q <= DW'(elem_data.by_coord) - DW'(elem_data.cy);
			b1_q <= DW'(elem_data.cy) - DW'(elem_data.ay);
			b2_q <= DW'(elem_data.ay) - DW'(elem_data.by_coord);
			c0_q <= DW'(elem_data.cx) - DW'(elem_data.bx);
			c1_q <= DW'(elem_data.ax) - DW'(elem_data.cx);
			c2_q <= DW'(elem_data.bx) - DW'(elem_data.ax);
		end
	end

	// ---------------- stage 0 -> s1: operand select, small products, det ----------
	logic signed [DW-1:0] bi, bj, ci, cj, u, v, s, t;
	logic signed [DW-1:0] ni, nj;
	logic signed [31:0] dsel;
	logic p_dir, q_dir;
	logic signed [tes_pkg::DET_W-1:0] det;
	logic [tes_pkg::DET_W-1:0] det_abs;
	tes_pkg::meta_t meta0;

	always_comb begin
		p_dir = cpq_q[1];
		q_dir = cpq_q[0];
		bi = tes_pkg::sel3(ci_q, b0_q, b1_q, b2_q);
		bj = tes_pkg::sel3(cj_q, b0_q, b1_q, b2_q);
		ci = tes_pkg::sel3(ci_q, c0_q, c1_q, c2_q);
		cj = tes_pkg::sel3(cj_q, c0_q, c1_q, c2_q);
		ni = tes_pkg::sel3(ci_q, DW'(n0_q), DW'(n1_q), DW'(n2_q));
		nj = tes_pkg::sel3(cj_q, DW'(n0_q), DW'(n1_q), DW'(n2_q));
		u = p_dir ? ci : bi;
		v = q_dir ? cj : bj;
		s = p_dir ? bi : ci;
		t = q_dir ? bj : cj;
		dsel = (p_dir ^ q_dir) ? d_cross_q : d_normal_q;
		det = tes_pkg::DET_W'(c2_q) * tes_pkg::DET_W'(b1_q)
			- tes_pkg::DET_W'(c1_q) * tes_pkg::DET_W'(b2_q);
		det_abs = det[tes_pkg::DET_W-1] ? tes_pkg::DET_W'(-det) : tes_pkg::DET_W'(det);
		meta0.row   = {ni[tes_pkg::NODE_W-1:0], p_dir};
		meta0.col   = {nj[tes_pkg::NODE_W-1:0], q_dir};
		meta0.degen = (det == '0);
		meta0.last  = last_issue;
		meta0.dvsr  = {det_abs, 1'b0};
	end

	logic vld_s1;
	logic [31:0] uv_s1, st_s1, dm_s1, em_s1;
	logic n1_s1, n2_s1;
	tes_pkg::meta_t meta_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (adv)
			vld_s1 <= elem_vld_q;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			uv_s1 <= 32'(tes_pkg::mag17(u)) * 32'(tes_pkg::mag17(v));
			st_s1 <= 32'(tes_pkg::mag17(s)) * 32'(tes_pkg::mag17(t));
			dm_s1 <= tes_pkg::mag32(dsel);
			em_s1 <= tes_pkg::mag32(d_shear_q);
			n1_s1 <= u[DW-1] ^ v[DW-1] ^ dsel[31];
			n2_s1 <= s[DW-1] ^ t[DW-1] ^ d_shear_q[31];
			meta_s1 <= meta0;
		end
	end

	// ---------------- s2: wide products ----------------
	logic vld_s2;
	logic [63:0] m1_s2, m2_s2;
	logic n1_s2, n2_s2;
	tes_pkg::meta_t meta_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (adv)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m1_s2 <= 64'(uv_s1) * 64'(dm_s1);
			m2_s2 <= 64'(st_s1) * 64'(em_s1);
			n1_s2 <= n1_s1;
			n2_s2 <= n2_s1;
			meta_s2 <= meta_s1;
		end
	end

	// ---------------- s3: signed sum as sign and magnitude ----------------
	logic vld_s3;
	logic [63:0] mag_s3;
	logic neg_s3;
	tes_pkg::meta_t meta_s3;
	logic sn1, sn2, sneg;
	logic [63:0] smag;

	always_comb begin
		sn1 = n1_s2 && (m1_s2 != '0);
		sn2 = n2_s2 && (m2_s2 != '0);
		if (sn1 == sn2) begin
			sneg = sn1;
			smag = m1_s2 + m2_s2;
		end else if (m1_s2 >= m2_s2) begin
			sneg = sn1;
			smag = m1_s2 - m2_s2;
		end else begin
			sneg = sn2;
			smag = m2_s2 - m1_s2;
		end
		if (smag == '0)
			sneg = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (adv)
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s3 <= smag;
			neg_s3 <= sneg;
			meta_s3 <= meta_s2;
		end
	end

	// ---------------- divide: one quotient bit per stage ----------------
	tes_pkg::dstg_t div_s [0:NSTG];
	logic [NSTG:0] div_vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_vld_s <= '0;
		else if (adv)
			div_vld_s <= {div_vld_s[NSTG-1:0], vld_s3};
	end

	// quotient would reach 2^48: saturate regardless of the low bits
	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0].rem  <= mag_s3;
			div_s[0].quo  <= '0;
			div_s[0].sat  <= {20'd0, mag_s3[63:48]} >= meta_s3.dvsr;
			div_s[0].neg  <= neg_s3;
			div_s[0].meta <= meta_s3;
		end
	end

	for (genvar k = 1; k <= NSTG; k++) begin : g_div
		localparam int BIT = NSTG - k;
		logic ge;
		assign ge = (div_s[k-1].rem >> BIT) >= 64'(div_s[k-1].meta.dvsr);
		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[k].rem <= ge ? div_s[k-1].rem - (64'(div_s[k-1].meta.dvsr) << BIT)
					: div_s[k-1].rem;
				div_s[k].quo  <= div_s[k-1].quo | (ge ? (48'd1 << BIT) : 48'd0);
				div_s[k].sat  <= div_s[k-1].sat;
				div_s[k].neg  <= div_s[k-1].neg;
				div_s[k].meta <= div_s[k-1].meta;
			end
		end
	end

	// ---------------- rounding (half away from zero) ----------------
	logic rnd_vld_s;
	logic [48:0] qr_s;
	logic neg_rs, sat_rs;
	tes_pkg::meta_t meta_rs;
	logic rup;

	assign rup = div_s[NSTG].rem >= (64'(div_s[NSTG].meta.dvsr) - div_s[NSTG].rem);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rnd_vld_s <= 1'b0;
		else if (adv)
			rnd_vld_s <= div_vld_s[NSTG];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qr_s    <= {1'b0, div_s[NSTG].quo} + {48'd0, rup};
			neg_rs  <= div_s[NSTG].neg;
			sat_rs  <= div_s[NSTG].sat;
			meta_rs <= div_s[NSTG].meta;
		end
	end

	// ---------------- saturate, sign, output register ----------------
	logic [48:0] lim;
	logic [47:0] kmag, kval;

	always_comb begin
		lim  = neg_rs ? (49'd1 << 47) : ((49'd1 << 47) - 49'd1);
		kmag = (sat_rs || (qr_s > lim)) ? lim[47:0] : qr_s[47:0];
		kval = neg_rs ? 48'(-kmag) : kmag;
	end

	tes_pkg::trip_t trip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (adv)
			out_vld_q <= rnd_vld_s;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			trip_q.row_index  <= meta_rs.row;
			trip_q.col_index  <= meta_rs.col;
			trip_q.stiffness  <= meta_rs.degen ? 48'sd0 : $signed(kval);
			trip_q.degenerate <= meta_rs.degen;
			trip_q.last       <= meta_rs.last;
		end
	end

	assign trip_valid = out_vld_q;
	assign trip_data  = trip_q;

endmodule
